// File: sv/sorted_table_binary_search_assert.svh
// ----------------------------------------------------------------------------
// Sorted table binary search: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// same-cycle implication
`define STBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stbs: same-cycle check failed");

// next-cycle implication
`define STBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stbs: next-cycle check failed");

`endif

// File: sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: package
// Transaction types, controller/datapath interface types and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_WORD_WIDTH  = 32;
  localparam int INDEX_W         = 10;
  localparam int VALUE_W         = 32;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic [INDEX_W-1:0]         load_index;
    logic signed [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]         range_low;
    logic [INDEX_W-1:0]         range_high;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } rsp_t;

  typedef struct packed {
    logic load;     // write table word
    logic start;    // capture query
    logic first;    // first probe at midpoint
    logic advance;  // narrow range and probe again
    logic finish;   // capture result
    logic found;    // result flag for finish
    logic push;     // move result to output register
  } cmd_t;

  typedef struct packed {
    logic empty;       // range empty before first probe
    logic match;       // probed word equals key
    logic next_empty;  // narrowed range would be empty
    logic out_free;    // output register can take a result
  } status_t;

endpackage

`default_nettype wire

// File: sv/stbs_ram.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: controller
// Sequences load, setup, probe and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl
  import stbs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  input  wire kind_e   req_kind_i,
  output logic         req_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        req_stall_o = 1'b0;
        if (req_valid_i) begin
          if (req_kind_i == KIND_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SETUP;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        if (status_i.empty) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_HOLD;
        end else begin
          cmd_o.first = 1'b1;
          state_d     = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status_i.match) begin
          cmd_o.finish = 1'b1;
          cmd_o.found  = 1'b1;
          state_d      = ST_HOLD;
        end else if (status_i.next_empty) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_HOLD;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_HOLD: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/stbs_dp.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: datapath
// Table RAM, search bounds, midpoint selection, compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_table_binary_search_assert.svh"

module stbs_dp
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire req_t req_i,
  input  wire cmd_t cmd_i,
  output status_t   status_o,
  input  wire logic rsp_stall_i,
  output logic      rsp_valid_o,
  output rsp_t      rsp_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);
  localparam logic [CW:0]   ONE_C   = (CW+1)'(1);

  logic signed [WORD_WIDTH-1:0] word_in;
  logic signed [WORD_WIDTH-1:0] key_q;
  logic signed [WORD_WIDTH-1:0] rd_word;
  logic [WORD_WIDTH-1:0]        rdata;
  logic [CW-1:0]                idx_ext;
  logic [CW-1:0]                hi_in;
  logic [CW-1:0]                hi_sat;
  logic [CW-1:0]                lo_q, hi_q, mid_q;
  logic [CW:0]                  sum0, sum_up, sum_dn;
  logic [CW-1:0]                mid0, mid_up, mid_dn;
  logic                         below;
  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_raddr;
  rsp_t                         res_q, rsp_q;
  logic                         out_valid_q;

  assign word_in = WORD_WIDTH'($signed(req_i.value));
  assign idx_ext = CW'(req_i.load_index);
  assign hi_in   = CW'(req_i.range_high);
  assign hi_sat  = (hi_in > LAST_C) ? LAST_C : hi_in;
  assign ram_we  = cmd_i.load && (idx_ext < DEPTH_C);

  assign sum0   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid0   = sum0[CW:1];
  assign sum_up = {1'b0, mid_q} + ONE_C + {1'b0, hi_q};
  assign mid_up = sum_up[CW:1];
  assign sum_dn = {1'b0, lo_q} + {1'b0, mid_q} - ONE_C;
  assign mid_dn = sum_dn[CW:1];

  assign rd_word = $signed(rdata);
  assign below   = rd_word < key_q;

  assign ram_re    = cmd_i.first || cmd_i.advance;
  assign ram_raddr = cmd_i.first ? mid0[AW-1:0] : (below ? mid_up[AW-1:0] : mid_dn[AW-1:0]);

  stbs_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (word_in),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= word_in;
      lo_q  <= CW'(req_i.range_low);
      hi_q  <= hi_sat;
    end
    if (cmd_i.first) begin
      mid_q <= mid0;
    end
    if (cmd_i.advance) begin
      if (below) begin
        lo_q  <= mid_q + CW'(1);
        mid_q <= mid_up;
      end else begin
        hi_q  <= mid_q - CW'(1);
        mid_q <= mid_dn;
      end
    end
    if (cmd_i.finish) begin
      res_q.found    <= cmd_i.found;
      res_q.position <= cmd_i.found ? INDEX_W'(mid_q) : '0;
    end
    if (cmd_i.push) begin
      rsp_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.empty      = lo_q > hi_q;
  assign status_o.match      = rd_word == key_q;
  assign status_o.next_empty = below ? (mid_q == hi_q) : (mid_q == lo_q);
  assign status_o.out_free   = !out_valid_q || !rsp_stall_i;

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  `STBS_ASSERT_NEXT(a_bounds_ordered, cmd_i.advance, lo_q <= hi_q)
  `STBS_ASSERT_NEXT(a_mid_in_range, cmd_i.advance, (mid_q >= lo_q) && (mid_q <= hi_q))
  `STBS_ASSERT_NOW(a_push_when_free, cmd_i.push, status_o.out_free)
  `STBS_ASSERT_NOW(a_miss_pos_zero, out_valid_q && !rsp_q.found, rsp_q.position == '0)

endmodule

`default_nettype wire

// File: sv/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: top level
// Loadable table of signed words with an iterative binary search query.
// ----------------------------------------------------------------------------
// Input channel req (valid/stall): a load transaction writes one word at
// load_index and returns nothing; a query transaction searches [range_low,
// range_high] for value and returns one rsp transaction (found, position).
// A load never stalls the input; the next transaction can follow at once.
// A query runs a setup state, then one table read per probe, 0 to
// clog2(TABLE_DEPTH)+1 probes (11 at depth 1024), then a hold state that
// hands the result over to the output register.
// The single table RAM read port, one read per probe, paces the search.
// One query is in flight at a time; req_stall_o is high while it runs.
// Results sit in an output register: while rsp_stall_i holds it, the block
// takes the next transaction and parks a finished result until the
// register frees up.
// Reset clears control and the output valid flag; table contents stay
// undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_stall_o,
  input  wire req_t req_i,
  output logic      rsp_valid_o,
  input  wire logic rsp_stall_i,
  output rsp_t      rsp_o
);

  cmd_t    cmd;
  status_t status;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_kind_i  (req_i.kind),
    .req_stall_o (req_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_stall_i (rsp_stall_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// File: sim/search_result_checker.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: result checker
// Watches both channels. It mirrors table loads, works out the answer to
// each accepted query and compares every result transaction, in order,
// against the oldest answer still outstanding.
// ----------------------------------------------------------------------------
module search_result_checker
  import stbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_stall_i,
  input  req_t req_i,
  input  logic rsp_valid_i,
  input  logic rsp_stall_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEF_TABLE_DEPTH;

  logic signed [VALUE_W-1:0] table_words [DEPTH];
  rsp_t                      expected_rsps [$];

  function automatic rsp_t search_table(input logic signed [VALUE_W-1:0] key,
                                        input int lo, input int hi);
    rsp_t r;
    int   mid;
    r = '0;
    if (hi > DEPTH - 1) hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (table_words[mid] == key) begin
        r.found    = 1'b1;
        r.position = mid[INDEX_W-1:0];
        return r;
      end
      if (table_words[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      expected_rsps.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (req_valid_i && !req_stall_i) begin
        if (req_i.kind == KIND_LOAD) begin
          table_words[req_i.load_index] = req_i.value;
        end else begin
          expected_rsps.push_back(search_table(req_i.value, int'(req_i.range_low),
                                               int'(req_i.range_high)));
        end
      end
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transaction: found=%0d position=%0d",
                 rsp_i.found, rsp_i.position);
          fail_count_o++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, rsp_i.found);
            fail_count_o++;
          end
          if (rsp_i.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, rsp_i.position);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_rsps.size();
    end
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: testbench top
// Loads sorted (and sometimes unsorted) regions of the table and issues
// queries over them: hits, misses, empty ranges and full-table ranges.
// Any entry a query would probe is loaded first, so no unwritten word is
// ever read. Both channels idle in random bursts; the checker does the
// comparison and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stbs_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int ITEMS = 750;
  localparam int LIMIT = 2000;
  localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;
  int   fail_count;
  int   pending;

  bit   send_idle;
  bit   recv_idle;
  int   stall_left;
  int   n_items;
  int   quiet_cycles;
  int   region_lo;
  int   region_hi;

  logic signed [VALUE_W-1:0] shadow [DEPTH];
  bit                        written [DEPTH];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_table_binary_search dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_valid),
    .req_stall_o(req_stall),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_stall_i(rsp_stall),
    .rsp_o      (rsp)
  );

  search_result_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_stall_i (req_stall),
    .req_i       (req),
    .rsp_valid_i (rsp_valid),
    .rsp_stall_i (rsp_stall),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(negedge clk) begin
    if (!recv_idle) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= LIMIT) begin
      $display("** sorted_table_binary_search: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [VALUE_W-1:0] clamp_word(input longint x);
    if (x > longint'(WORD_MAX)) return WORD_MAX;
    if (x < longint'(WORD_MIN)) return WORD_MIN;
    return x[VALUE_W-1:0];
  endfunction

  // word close to the key, so that on-demand loads keep the search going
  function automatic logic signed [VALUE_W-1:0] near_word(input logic signed [VALUE_W-1:0] key);
    case ($urandom_range(0, 4))
      0:       return key;
      1, 2:    return clamp_word(longint'(key) - $urandom_range(1, 1000));
      default: return clamp_word(longint'(key) + $urandom_range(1, 1000));
    endcase
  endfunction

  task automatic send_req(input req_t r);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  task automatic load_word(input int idx, input logic signed [VALUE_W-1:0] v);
    req_t r;
    r            = '0;
    r.kind       = KIND_LOAD;
    r.load_index = idx[INDEX_W-1:0];
    r.value      = v;
    r.range_low  = INDEX_W'($urandom);
    r.range_high = INDEX_W'($urandom);
    send_req(r);
    shadow[idx]  = v;
    written[idx] = 1'b1;
  endtask

  task automatic fill_region(input int a, input int b);
    int                        mode;
    int                        i;
    int                        idx;
    int                        step_max;
    bit                        down;
    longint                    acc;
    logic signed [VALUE_W-1:0] v;
    mode = $urandom_range(0, 4);
    down = 1'b0;
    case (mode)
      0: begin acc = longint'($signed($urandom)); step_max = 3; end
      1: begin acc = longint'(WORD_MIN) + $urandom_range(0, 3); step_max = 1 << 23; end
      2: begin acc = longint'(WORD_MAX); step_max = 1 << 23; down = 1'b1; end
      default: begin acc = longint'($signed($urandom)) / 4; step_max = 100000; end
    endcase
    for (i = 0; i <= b - a; i++) begin
      idx = down ? b - i : a + i;
      if (mode == 4) begin
        v = $urandom;
      end else begin
        v = clamp_word(acc);
        if (down) acc -= $urandom_range(0, step_max);
        else acc += $urandom_range(0, step_max);
      end
      load_word(idx, v);
    end
    region_lo = a;
    region_hi = b;
  endtask

  task automatic run_query(input logic signed [VALUE_W-1:0] key, input int lo, input int hi);
    int   l;
    int   h;
    int   mid;
    req_t r;
    l = lo;
    h = (hi > DEPTH - 1) ? DEPTH - 1 : hi;
    while (l <= h) begin
      mid = (l + h) / 2;
      if (!written[mid]) load_word(mid, near_word(key));
      if (shadow[mid] == key) break;
      if (shadow[mid] < key) l = mid + 1;
      else h = mid - 1;
    end
    r            = '0;
    r.kind       = KIND_QUERY;
    r.load_index = INDEX_W'($urandom);
    r.value      = key;
    r.range_low  = lo[INDEX_W-1:0];
    r.range_high = hi[INDEX_W-1:0];
    send_req(r);
  endtask

  task automatic random_query();
    int                        l;
    int                        h;
    int                        pick;
    int                        idx;
    logic signed [VALUE_W-1:0] key;
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      l = $urandom_range(region_lo, region_hi);
      h = $urandom_range(l, region_hi);
      if (pick < 4) begin
        l = region_lo;
        h = region_hi;
      end
    end else if (pick < 19) begin
      l = $urandom_range(0, DEPTH - 1);
      h = $urandom_range(0, DEPTH - 1);
    end else begin
      l = 0;
      h = DEPTH - 1;
    end
    pick = $urandom_range(0, 9);
    if (l <= h && pick < 6 && written[(l + h) / 2]) begin
      idx = $urandom_range(l, h);
      key = written[idx] ? shadow[idx] : shadow[(l + h) / 2];
    end else if (pick < 8 && written[l]) begin
      key = clamp_word(longint'(shadow[l]) + ($urandom_range(0, 1) ? 1 : -1));
    end else if (pick == 8) begin
      key = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
    end else begin
      key = $urandom;
    end
    run_query(key, l, h);
  endtask

  initial begin
    int next_toggle;
    int len;
    int a;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // upper bound drops below zero, then edge words and ranges
    load_word(0, 10);
    run_query(3, 0, 0);
    load_word(0, WORD_MIN);
    load_word(1, -1);
    load_word(2, 0);
    load_word(3, 1);
    run_query(WORD_MIN, 0, 3);
    run_query(1, 0, 3);
    run_query(7, 0, 3);
    run_query(-5, 0, 3);
    run_query(0, 5, 4);
    load_word(DEPTH - 1, WORD_MAX);
    load_word(DEPTH - 2, 5);
    run_query(WORD_MAX, DEPTH - 1, DEPTH - 1);
    run_query(WORD_MAX, DEPTH - 2, DEPTH - 1);
    run_query(WORD_MIN, DEPTH - 1, 0);
    run_query(0, 0, DEPTH - 1);
    region_lo = 0;
    region_hi = 3;

    next_toggle = 0;
    while (n_items < ITEMS) begin
      if (n_items >= ITEMS - 100) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else if (n_items >= next_toggle) begin
        send_idle   = ($urandom_range(0, 3) != 0);
        recv_idle   = ($urandom_range(0, 3) != 0);
        next_toggle = n_items + $urandom_range(20, 60);
      end
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 48);
        a   = $urandom_range(0, DEPTH - len);
        fill_region(a, a + len - 1);
      end else begin
        random_query();
      end
    end
    req_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("** sorted_table_binary_search: PASSED **");
    end else begin
      $display("** sorted_table_binary_search: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/stbs_pkg.sv
sv/stbs_ram.sv
sv/stbs_ctrl.sv
sv/stbs_dp.sv
sv/sorted_table_binary_search.sv
sim/search_result_checker.sv
sim/testbench.sv
